/* src/ordered_array_list_table_defines.svh */
// Assertion macros shared by the ordered array list table RTL.
// Depends on nothing; included by the top level only.
`ifndef ORDERED_ARRAY_LIST_TABLE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define OALT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oalt assertion failed");
`define OALT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oalt assertion failed");
`else
`define OALT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OALT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/oalt_pkg.sv */
// Types and codes of the ordered array list table.
// No dependencies; imported by oalt_ctrl, the top level and the testbench.
package oalt_pkg;

    localparam logic [2:0] REQ_CLEAR  = 3'd0;
    localparam logic [2:0] REQ_INSERT = 3'd1;
    localparam logic [2:0] REQ_DELETE = 3'd2;
    localparam logic [2:0] REQ_FIND   = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;
    localparam logic [2:0] REQ_UPDATE = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  position;
        logic        append_at_end;
        logic [63:0] item_key;
        logic [31:0] item_payload;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  result_position;
        logic [63:0] result_key;
        logic [31:0] result_payload;
        logic [5:0]  entry_count;
    } out_t;

endpackage

/* src/oalt_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module oalt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/oalt_ctrl.sv */
// Request sequencer: decodes a transaction and walks the entry RAM to shift, search or access it.
// Depends on oalt_pkg; drives one oalt_ram instance through its ports.
module oalt_ctrl #(
    parameter int LIST_DEPTH   = 32,
    parameter int KEY_BITS     = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  oalt_pkg::in_t                         in_data,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output oalt_pkg::out_t                        res_data,
    output logic                                  ram_wr_en,
    output logic [$clog2(LIST_DEPTH)-1:0]         ram_wr_addr,
    output logic [KEY_BITS+PAYLOAD_BITS-1:0]      ram_wr_data,
    output logic                                  ram_rd_en,
    output logic [$clog2(LIST_DEPTH)-1:0]         ram_rd_addr,
    input  logic [KEY_BITS+PAYLOAD_BITS-1:0]      ram_rd_data
);

    import oalt_pkg::*;

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SH_RD,
        S_SH_WR,
        S_INS_WR,
        S_FIND_RD,
        S_FIND_CMP,
        S_RESP
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             shift_up_reg, shift_up_next;
    in_t              req_reg;
    out_t             res_reg, res_next;

    logic [CMP_W-1:0]        pos_ext;
    logic [CMP_W-1:0]        count_ext;
    logic [CMP_W-1:0]        at_ext;
    logic [IDX_W-1:0]        at_idx;
    logic [IDX_W-1:0]        pos_idx;
    logic [KEY_BITS-1:0]     req_key;
    logic [PAYLOAD_BITS-1:0] req_pay;
    logic [KEY_BITS-1:0]     rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic [CNT_W-1:0]        idx_plus_one;

    assign pos_ext      = CMP_W'(req_reg.position);
    assign count_ext    = CMP_W'(count_reg);
    assign at_ext       = req_reg.append_at_end ? count_ext : pos_ext;
    assign at_idx       = at_ext[IDX_W-1:0];
    assign pos_idx      = pos_ext[IDX_W-1:0];
    assign req_key      = KEY_BITS'(req_reg.item_key);
    assign req_pay      = PAYLOAD_BITS'(req_reg.item_payload);
    assign rd_key       = ram_rd_data[KEY_BITS+PAYLOAD_BITS-1:PAYLOAD_BITS];
    assign rd_pay       = ram_rd_data[PAYLOAD_BITS-1:0];
    assign idx_plus_one = CNT_W'(idx_reg) + CNT_W'(1);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);

    always_comb
    begin
        res_data             = res_reg;
        res_data.entry_count = 6'(count_reg);
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        shift_up_next = shift_up_reg;
        res_next      = res_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = idx_reg;
        ram_wr_data   = {req_key, req_pay};
        ram_rd_en     = 1'b0;
        ram_rd_addr   = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_next.status          = ST_OK;
                res_next.result_position = req_reg.position;
                res_next.result_key      = '0;
                res_next.result_payload  = '0;
                res_next.entry_count     = '0;
                state_next               = S_RESP;
                unique case (req_reg.req_type)
                    REQ_CLEAR:
                    begin
                        count_next = '0;
                    end
                    REQ_INSERT:
                    begin
                        if (count_reg == CNT_W'(LIST_DEPTH))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else if (at_ext > count_ext)
                        begin
                            res_next.status = ST_RANGE;
                        end
                        else if (at_ext == count_ext)
                        begin
                            state_next = S_INS_WR;
                        end
                        else
                        begin
                            idx_next      = count_reg[IDX_W-1:0];
                            shift_up_next = 1'b1;
                            state_next    = S_SH_RD;
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (pos_ext >= count_ext)
                        begin
                            res_next.status = ST_RANGE;
                        end
                        else if (pos_ext + CMP_W'(1) == count_ext)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            idx_next      = pos_idx;
                            shift_up_next = 1'b0;
                            state_next    = S_SH_RD;
                        end
                    end
                    REQ_FIND:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_FIND_RD;
                        end
                    end
                    REQ_READ:
                    begin
                        if (pos_ext >= count_ext)
                        begin
                            res_next.status = ST_RANGE;
                        end
                        else
                        begin
                            idx_next   = pos_idx;
                            state_next = S_FIND_RD;
                        end
                    end
                    REQ_UPDATE:
                    begin
                        if (pos_ext >= count_ext)
                        begin
                            res_next.status = ST_RANGE;
                        end
                        else
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = pos_idx;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SH_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = shift_up_reg ? idx_reg - IDX_W'(1) : idx_reg + IDX_W'(1);
                state_next  = S_SH_WR;
            end
            S_SH_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg;
                ram_wr_data = ram_rd_data;
                if (shift_up_reg)
                begin
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = (idx_reg - IDX_W'(1) == at_idx) ? S_INS_WR : S_SH_RD;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (idx_plus_one == count_reg - CNT_W'(1))
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SH_RD;
                    end
                end
            end
            S_INS_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = at_idx;
                count_next  = count_reg + CNT_W'(1);
                state_next  = S_RESP;
            end
            S_FIND_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_reg;
                state_next  = S_FIND_CMP;
            end
            S_FIND_CMP:
            begin
                if (req_reg.req_type == REQ_READ)
                begin
                    res_next.result_key     = 64'(rd_key);
                    res_next.result_payload = 32'(rd_pay);
                    state_next              = S_RESP;
                end
                else if (rd_key == req_key)
                begin
                    res_next.result_position = 5'(idx_reg);
                    res_next.result_key      = 64'(rd_key);
                    res_next.result_payload  = 32'(rd_pay);
                    state_next               = S_RESP;
                end
                else if (idx_plus_one == count_reg)
                begin
                    res_next.status = ST_NOT_FOUND;
                    state_next      = S_RESP;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_FIND_RD;
                end
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            shift_up_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            shift_up_reg <= shift_up_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
        res_reg <= res_next;
    end

endmodule

/* src/ordered_array_list_table.sv */
// Ordered array list table: entries live in one RAM; each transaction is one request.
// Requests with no RAM walk go from decode straight to the result. Insert at p moves
// each entry from the end down to p up one place, then writes the new one; delete at p
// moves each entry above p down one place; read fetches one entry and find reads the
// entries in order to a match or the end. The sequencer handles one request at a time.
// Reset clears the entry count; RAM contents stay undefined and need no clearing pass.
module ordered_array_list_table #(
    parameter int LIST_DEPTH   = 32,
    parameter int KEY_BITS     = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  oalt_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output oalt_pkg::out_t out_data
);

    import oalt_pkg::*;

    `include "ordered_array_list_table_defines.svh"

    localparam int IDX_W  = $clog2(LIST_DEPTH);
    localparam int WORD_W = KEY_BITS + PAYLOAD_BITS;

    logic              res_valid;
    logic              res_ready;
    out_t              res_data;
    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;

    logic out_valid_reg;
    out_t out_data_reg;

    oalt_ctrl #(
        .LIST_DEPTH   (LIST_DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    oalt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LIST_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The output register frees the sequencer as soon as a result is handed over.
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `OALT_ASSERT_IMPL(a_one_at_a_time, clk, rst_n, in_ready, !res_valid)
    `OALT_ASSERT_NEXT(a_result_held, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_data))
    `OALT_ASSERT_IMPL(a_full_count, clk, rst_n, out_valid && out_data.status == ST_FULL, out_data.entry_count == 6'(LIST_DEPTH))
    `OALT_ASSERT_NEXT(a_accept_then_busy, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid_reg || !in_ready)

endmodule

/* tb/sv/ordered_list_check.sv */
// Checker for the ordered array list table: watches both channels, predicts each result
// from its own copy of the list and compares it field by field. Depends on oalt_pkg.
`timescale 1ns / 1ps

module ordered_list_check
    import oalt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_ready,
    input  in_t  in_data,
    input  logic out_valid,
    input  logic out_ready,
    input  out_t out_data,
    output int   mismatch_count,
    output int   outstanding,
    output int   predicted_entries
);

    localparam int LIST_DEPTH = 32;
    localparam int PRINT_CAP  = 40;

    logic [63:0] entry_key     [LIST_DEPTH];
    logic [31:0] entry_payload [LIST_DEPTH];
    int          list_len;
    int          fail_count;
    out_t        expected_results [$];
    out_t        want;

    assign mismatch_count = fail_count;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        if (fail_count < PRINT_CAP)
            $display("%0t ns mismatch in %s: got %0h, expected %0h", $realtime, field,
                     got, exp_val);
        fail_count++;
    endtask

    function automatic out_t apply_request(input in_t req);
        out_t res;
        int   at;
        logic found;
        res.status          = ST_OK;
        res.result_position = req.position;
        res.result_key      = '0;
        res.result_payload  = '0;
        found               = 1'b0;
        case (req.req_type)
            REQ_CLEAR:
                list_len = 0;
            REQ_INSERT:
            begin
                at = req.append_at_end ? list_len : int'(req.position);
                if (list_len >= LIST_DEPTH)
                    res.status = ST_FULL;
                else if (at > list_len)
                    res.status = ST_RANGE;
                else
                begin
                    for (int i = list_len; i > at; i--)
                    begin
                        entry_key[i]     = entry_key[i - 1];
                        entry_payload[i] = entry_payload[i - 1];
                    end
                    entry_key[at]     = req.item_key;
                    entry_payload[at] = req.item_payload;
                    list_len++;
                end
            end
            REQ_DELETE:
            begin
                if (int'(req.position) >= list_len)
                    res.status = ST_RANGE;
                else
                begin
                    for (int i = int'(req.position); i + 1 < list_len; i++)
                    begin
                        entry_key[i]     = entry_key[i + 1];
                        entry_payload[i] = entry_payload[i + 1];
                    end
                    list_len--;
                end
            end
            REQ_FIND:
            begin
                res.status = ST_NOT_FOUND;
                for (int i = 0; i < list_len; i++)
                begin
                    if (!found && entry_key[i] == req.item_key)
                    begin
                        found               = 1'b1;
                        res.status          = ST_OK;
                        res.result_position = 5'(i);
                        res.result_key      = entry_key[i];
                        res.result_payload  = entry_payload[i];
                    end
                end
            end
            REQ_READ:
            begin
                if (int'(req.position) >= list_len)
                    res.status = ST_RANGE;
                else
                begin
                    res.result_key     = entry_key[req.position];
                    res.result_payload = entry_payload[req.position];
                end
            end
            REQ_UPDATE:
            begin
                if (int'(req.position) >= list_len)
                    res.status = ST_RANGE;
                else
                begin
                    entry_key[req.position]     = req.item_key;
                    entry_payload[req.position] = req.item_payload;
                end
            end
            default:
                ;
        endcase
        res.entry_count = 6'(list_len);
        return res;
    endfunction

    initial
    begin
        fail_count = 0;
        list_len   = 0;
        foreach (entry_key[i])
        begin
            entry_key[i]     = '0;
            entry_payload[i] = '0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            list_len          = 0;
            outstanding       <= 0;
            predicted_entries <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(apply_request(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no transaction outstanding",
                                    64'(out_data.result_position), 64'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.status !== want.status)
                        report_mismatch("status", 64'(out_data.status), 64'(want.status));
                    if (out_data.result_position !== want.result_position)
                        report_mismatch("result_position", 64'(out_data.result_position),
                                        64'(want.result_position));
                    if (out_data.result_key !== want.result_key)
                        report_mismatch("result_key", out_data.result_key, want.result_key);
                    if (out_data.result_payload !== want.result_payload)
                        report_mismatch("result_payload", 64'(out_data.result_payload),
                                        64'(want.result_payload));
                    if (out_data.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 64'(out_data.entry_count),
                                        64'(want.entry_count));
                end
            end
            outstanding       <= expected_results.size();
            predicted_entries <= list_len;
        end
    end

endmodule

/* tb/sv/tb.sv */
// Top of the ordered array list table testbench: clock, reset, request stimulus and verdict.
// Depends on oalt_pkg, ordered_array_list_table and ordered_list_check.
`timescale 1ns / 1ps

module tb;
    import oalt_pkg::*;

    localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
    localparam int         ITEM_TARGET   = 1050;
    localparam int         SETTLE_CYCLES = 100;
    localparam int         DRAIN_LIMIT   = 20000;

    typedef enum int {MODE_FILL, MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_RESTART} mix_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_t         in_data;
    logic        out_valid;
    logic        out_ready;
    out_t        out_data;
    logic        quiet;
    int          mismatch_count;
    int          outstanding;
    int          predicted_entries;
    int          counted;
    logic [63:0] key_pool [8];

    ordered_array_list_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    ordered_list_check u_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .in_data           (in_data),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_data          (out_data),
        .mismatch_count    (mismatch_count),
        .outstanding       (outstanding),
        .predicted_entries (predicted_entries)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
        out_ready <= quiet || ($urandom_range(0, 99) >= 33);

    function automatic in_t make_request(input logic [2:0] kind, input logic [4:0] pos,
                                         input logic app, input logic [63:0] key,
                                         input logic [31:0] pay);
        in_t req;
        req.req_type      = kind;
        req.position      = pos;
        req.append_at_end = app;
        req.item_key      = key;
        req.item_payload  = pay;
        return req;
    endfunction

    function automatic logic [63:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return key_pool[$urandom_range(0, 7)];
        else if (roll < 52)
            return '0;
        else if (roll < 58)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic in_t random_request(input mix_t mode, input int n);
        in_t req;
        int  c_ins, c_del, c_find, c_read, c_upd, c_clr, roll, top_pos;
        case (mode)
            MODE_FILL:
            begin
                c_ins = 100; c_del = 100; c_find = 100; c_read = 100; c_upd = 100; c_clr = 100;
            end
            MODE_GROW:
            begin
                c_ins = 62; c_del = 68; c_find = 78; c_read = 88; c_upd = 96; c_clr = 96;
            end
            MODE_SHRINK:
            begin
                c_ins = 6; c_del = 64; c_find = 76; c_read = 88; c_upd = 96; c_clr = 96;
            end
            default:
            begin
                c_ins = 24; c_del = 44; c_find = 64; c_read = 78; c_upd = 92; c_clr = 96;
            end
        endcase
        roll              = $urandom_range(0, 99);
        req.append_at_end = 1'($urandom_range(0, 1));
        req.item_key      = pick_key();
        req.item_payload  = $urandom;
        top_pos           = (n > 31) ? 31 : n;
        if (roll < c_ins)
            req.req_type = REQ_INSERT;
        else if (roll < c_del)
            req.req_type = REQ_DELETE;
        else if (roll < c_find)
            req.req_type = REQ_FIND;
        else if (roll < c_read)
            req.req_type = REQ_READ;
        else if (roll < c_upd)
            req.req_type = REQ_UPDATE;
        else if (roll < c_clr)
            req.req_type = REQ_CLEAR;
        else
            req.req_type = $urandom_range(0, 1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
        if (req.req_type == REQ_INSERT)
            req.append_at_end = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 99) < 12)
            req.position = 5'($urandom_range(0, 31));
        else if (req.req_type == REQ_INSERT)
            req.position = 5'($urandom_range(0, top_pos));
        else if (n > 0)
            req.position = 5'($urandom_range(0, ((n > 32) ? 32 : n) - 1));
        else
            req.position = 5'($urandom_range(0, 31));
        return req;
    endfunction

    task automatic send_request(input in_t req);
        int gap;
        gap = 0;
        if (!quiet)
            while ($urandom_range(0, 99) < 33)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        if (req.req_type <= REQ_UPDATE)
            counted++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        int   guard;
        int   phase_len;
        mix_t mode;
        logic first_phase;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        quiet     = 1'b0;
        counted   = 0;
        foreach (key_pool[k])
            key_pool[k] = {$urandom, $urandom};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_request(REQ_CLEAR, 5'd0, 1'b0, '0, '0));
        send_request(make_request(REQ_READ, 5'd0, 1'b0, '0, '0));
        send_request(make_request(REQ_DELETE, 5'd0, 1'b1, '1, '1));
        send_request(make_request(REQ_UPDATE, 5'd31, 1'b0, '1, '1));
        send_request(make_request(REQ_FIND, 5'd0, 1'b0, '0, '0));
        send_request(make_request(REQ_INSERT, 5'd1, 1'b0, '1, '1));
        send_request(make_request(REQ_INSERT, 5'd0, 1'b0, '1, '1));
        send_request(make_request(REQ_INSERT, 5'd31, 1'b1, '0, '0));
        send_request(make_request(REQ_INSERT, 5'd1, 1'b0, key_pool[0], 32'ha5a5_5a5a));
        send_request(make_request(REQ_INSERT, 5'd3, 1'b0, key_pool[0], 32'h1234_5678));
        send_request(make_request(REQ_INSERT, 5'd5, 1'b0, key_pool[1], 32'hdead_beef));
        send_request(make_request(REQ_FIND, 5'd17, 1'b0, key_pool[0], '0));
        send_request(make_request(REQ_FIND, 5'd9, 1'b0, 64'h0123_4567_89ab_cdef, '0));
        send_request(make_request(REQ_READ, 5'd0, 1'b0, '0, '0));
        send_request(make_request(REQ_READ, 5'd3, 1'b0, '0, '0));
        send_request(make_request(REQ_READ, 5'd4, 1'b0, '0, '0));
        send_request(make_request(REQ_UPDATE, 5'd2, 1'b0, key_pool[1], 32'h0f0f_f0f0));
        send_request(make_request(REQ_FIND, 5'd0, 1'b0, key_pool[1], '0));
        send_request(make_request(REQ_DELETE, 5'd0, 1'b0, '0, '0));
        send_request(make_request(REQ_DELETE, 5'd2, 1'b0, '0, '0));
        send_request(make_request(REQ_DELETE, 5'd2, 1'b0, '0, '0));
        send_request(make_request(REQ_UNUSED_LO, 5'd0, 1'b0, '0, '0));
        send_request(make_request(REQ_UNUSED_HI, 5'd31, 1'b1, '1, '1));
        send_request(make_request(REQ_UPDATE, 5'd31, 1'b0, '0, '0));
        send_request(make_request(REQ_CLEAR, 5'd31, 1'b1, '1, '1));
        wait_drained();

        first_phase = 1'b1;
        while (counted < ITEM_TARGET)
        begin
            if (first_phase)
            begin
                mode      = MODE_FILL;
                phase_len = 36;
            end
            else
            begin
                mode      = mix_t'($urandom_range(1, 4));
                phase_len = $urandom_range(20, 60);
            end
            first_phase = 1'b0;
            if (mode == MODE_RESTART)
                send_request(make_request(REQ_CLEAR, 5'($urandom_range(0, 31)),
                                          1'($urandom_range(0, 1)), pick_key(), $urandom));
            repeat (phase_len)
            begin
                quiet <= (counted >= 450 && counted < 600);
                send_request(random_request(mode, predicted_entries));
            end
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end

        in_valid <= 1'b0;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (outstanding != 0 && guard < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (outstanding != 0)
            $display("%0d results still outstanding at the end of the run", outstanding);
        if (mismatch_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/oalt_pkg.sv
src/oalt_ram.sv
src/oalt_ctrl.sv
src/ordered_array_list_table.sv
tb/sv/ordered_list_check.sv
tb/sv/tb.sv
